>>> rtl/lpmr_pkg.sv
// Shared constants, codes and types of the length-prefixed message ring.
package lpmr_pkg;

  // Default geometry.
  localparam int unsigned RING_DEPTH_DEF   = 4096;
  localparam int unsigned HEADER_BYTES_DEF = 8;

  // Field widths.
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned LEN_W    = 12;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FREE_W   = 12;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned SIZE_W   = 13;

  // Limits.
  localparam int unsigned MIN_SIZE    = 16;
  localparam int unsigned RESET_SIZE  = 4096;
  localparam int unsigned COUNT_MAX   = 511;
  localparam int unsigned NARROW_MAX  = 255;

  // Item modes.
  typedef enum logic [MODE_W-1:0] {
    MODE_HDR  = 2'd0,
    MODE_BYTE = 2'd1,
    MODE_POP  = 2'd2
  } mode_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2,
    STS_SEQ   = 2'd3
  } status_t;

endpackage

>>> rtl/lpmr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lpmr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/length_prefixed_message_ring.sv
// Top level of the length-prefixed message ring: control sequencer around one byte RAM.
//
//  channel | direction | handshake            | beat
//  in_     | input     | in_valid / in_stall   | mode, msg_length, data_byte
//  out_    | output    | out_valid / out_stall | status, read_byte, read_length, first,
//          |           |                       | last, free_bytes, message_count
//  cfg_    | input     | cfg_valid / cfg_ready | ring_size write data
//
// Payload byte push, errors, full and empty: answered from idle. Header push: one RAM
// write per header byte in ST_HDR_WR. Pop of a following byte: RAM read, then
// ST_POP_OUT. Pop of a message's first byte: two header reads, then the byte.
// Reset is synchronous and clears positions and counts; the RAM is not cleared.
// The result register holds its beat while out_stall is high; a new beat is stalled
// while the sequencer is busy, the result is full and stalled, or cfg_valid is high.
module length_prefixed_message_ring #(
  parameter int unsigned RING_DEPTH   = lpmr_pkg::RING_DEPTH_DEF,
  parameter int unsigned HEADER_BYTES = lpmr_pkg::HEADER_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lpmr_pkg::MODE_W-1:0]   in_mode,
  input  logic [lpmr_pkg::LEN_W-1:0]    in_msg_length,
  input  logic [lpmr_pkg::BYTE_W-1:0]   in_data_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lpmr_pkg::STATUS_W-1:0] out_status,
  output logic [lpmr_pkg::BYTE_W-1:0]   out_read_byte,
  output logic [lpmr_pkg::LEN_W-1:0]    out_read_length,
  output logic                          out_first,
  output logic                          out_last,
  output logic [lpmr_pkg::FREE_W-1:0]   out_free_bytes,
  output logic [lpmr_pkg::COUNT_W-1:0]  out_message_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lpmr_pkg::SIZE_W-1:0]   cfg_data
);

  localparam int unsigned PW  = $clog2(RING_DEPTH);
  localparam int unsigned SW  = PW + 1;
  localparam int unsigned CW  = (SW > lpmr_pkg::LEN_W + 1) ? SW : lpmr_pkg::LEN_W + 1;
  localparam int unsigned HCW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
  localparam int unsigned SIZE_RST =
    (lpmr_pkg::RESET_SIZE > RING_DEPTH) ? RING_DEPTH : lpmr_pkg::RESET_SIZE;
  localparam int unsigned LW  = lpmr_pkg::LEN_W;
  localparam int unsigned BW  = lpmr_pkg::BYTE_W;
  localparam int unsigned NW  = lpmr_pkg::COUNT_W;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_HDR_WR  = 5'b00010,
    ST_HDR_LO  = 5'b00100,
    ST_HDR_LEN = 5'b01000,
    ST_POP_OUT = 5'b10000
  } state_t;

  // Control state.
  state_t          state_r,    state_nxt;
  logic [SW-1:0]   size_r,     size_nxt;
  logic [PW-1:0]   wpos_r,     wpos_nxt;
  logic [PW-1:0]   cpos_r,     cpos_nxt;
  logic [PW-1:0]   rpos_r,     rpos_nxt;
  logic [PW-1:0]   used_r,     used_nxt;
  logic [LW-1:0]   push_rem_r, push_rem_nxt;
  logic [LW-1:0]   pop_rem_r,  pop_rem_nxt;
  logic [LW-1:0]   plen_r,     plen_nxt;
  logic [NW-1:0]   msgs_r,     msgs_nxt;
  logic [PW-1:0]   pop_ptr_r,  pop_ptr_nxt;
  logic            first_r,    first_nxt;
  logic [HCW-1:0]  hcnt_r,     hcnt_nxt;
  // Working payload.
  logic [LW-1:0]   hdr_len_r,  hdr_len_nxt;
  logic [PW-1:0]   wa_r,       wa_nxt;
  logic [BW-1:0]   lo_r,       lo_nxt;

  // Result register.
  logic                          out_valid_r;
  logic [lpmr_pkg::STATUS_W-1:0] out_status_r;
  logic [BW-1:0]                 out_read_byte_r;
  logic [LW-1:0]                 out_read_length_r;
  logic                          out_first_r;
  logic                          out_last_r;
  logic [lpmr_pkg::FREE_W-1:0]   out_free_bytes_r;
  logic [NW-1:0]                 out_message_count_r;

  // Result of the current step.
  logic                 res_load;
  lpmr_pkg::status_t    res_status;
  logic [BW-1:0]        res_byte;
  logic [LW-1:0]        res_len;
  logic                 res_first;
  logic                 res_last;

  // RAM port signals.
  logic          ram_we;
  logic [PW-1:0] ram_waddr;
  logic [BW-1:0] ram_wdata;
  logic [PW-1:0] ram_raddr;
  logic [BW-1:0] ram_rdata;

  // Arithmetic helpers.
  logic [SW-1:0]   cfg_size;
  logic [PW-1:0]   size_m1;
  logic [PW-1:0]   free_cur;
  logic [LW:0]     need;
  logic            need_fits;
  logic            too_long;
  logic [CW:0]     wsum;
  logic [PW-1:0]   wpos_adv;
  logic [PW-1:0]   pl_addr;
  logic [SW-1:0]   hsum;
  logic [PW-1:0]   hdr_end;
  logic [LW-1:0]   hlen;
  logic [BW-1:0]   hdr_byte;
  logic            cfg_fire;
  logic            in_fire;
  logic            out_free;

  // Step a position by one with wrap at the ring size.
  function automatic logic [PW-1:0] inc_wrap(input logic [PW-1:0] p,
                                             input logic [SW-1:0] s);
    logic [SW-1:0] n;
    n = SW'(p) + SW'(1);
    return (n >= s) ? '0 : PW'(n);
  endfunction

  // Release bytes from the used count, floored at zero.
  function automatic logic [PW-1:0] sub_sat(input logic [PW-1:0] u,
                                            input logic [CW-1:0] t);
    return (CW'(u) >= t) ? PW'(CW'(u) - t) : '0;
  endfunction

  // Count a committed message, saturating.
  function automatic logic [NW-1:0] cnt_inc(input logic [NW-1:0] c);
    return (c == NW'(lpmr_pkg::COUNT_MAX)) ? c : c + NW'(1);
  endfunction

  // Drop a finished message from the count, floored at zero.
  function automatic logic [NW-1:0] cnt_dec(input logic [NW-1:0] c);
    return (c == '0) ? c : c - NW'(1);
  endfunction

  // Handshakes.
  assign cfg_ready = (state_r == ST_IDLE);
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !out_free || cfg_valid;
  assign in_fire   = in_valid && !in_stall;

  // Clamp a written ring size into the usable range.
  always_comb begin
    if (cfg_data < lpmr_pkg::SIZE_W'(lpmr_pkg::MIN_SIZE)) begin
      cfg_size = SW'(lpmr_pkg::MIN_SIZE);
    end else if (32'(cfg_data) > RING_DEPTH) begin
      cfg_size = SW'(RING_DEPTH);
    end else begin
      cfg_size = SW'(cfg_data);
    end
  end

  // Free space and header reservation.
  assign size_m1   = PW'(size_r - SW'(1));
  assign free_cur  = size_m1 - used_r;
  assign need      = (LW+1)'(in_msg_length) + (LW+1)'(HEADER_BYTES);
  assign need_fits = CW'(need) <= CW'(free_cur);
  assign too_long  = (HEADER_BYTES < 2) && (in_msg_length > LW'(lpmr_pkg::NARROW_MAX));
  assign wsum      = (CW+1)'(wpos_r) + (CW+1)'(need);
  assign wpos_adv  = (wsum >= (CW+1)'(size_r)) ? PW'(wsum - (CW+1)'(size_r)) : PW'(wsum);

  // Payload byte lands push_remaining bytes behind the reservation end.
  always_comb begin
    if (CW'(wpos_r) >= CW'(push_rem_r)) begin
      pl_addr = PW'(CW'(wpos_r) - CW'(push_rem_r));
    end else begin
      pl_addr = PW'(CW'(wpos_r) + CW'(size_r) - CW'(push_rem_r));
    end
  end

  // First payload byte of the message at the read position.
  assign hsum    = SW'(rpos_r) + SW'(HEADER_BYTES);
  assign hdr_end = (hsum >= size_r) ? PW'(hsum - size_r) : PW'(hsum);

  // Length from the header bytes; a one-byte header carries the low byte only.
  assign hlen = (HEADER_BYTES >= 2) ? {ram_rdata[LW-BW-1:0], lo_r} : LW'(lo_r);

  // Little-endian header byte under the write counter.
  always_comb begin
    if (hcnt_r == HCW'(0)) begin
      hdr_byte = hdr_len_r[BW-1:0];
    end else if (hcnt_r == HCW'(1)) begin
      hdr_byte = BW'(hdr_len_r[LW-1:BW]);
    end else begin
      hdr_byte = '0;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt    = state_r;
    size_nxt     = size_r;
    wpos_nxt     = wpos_r;
    cpos_nxt     = cpos_r;
    rpos_nxt     = rpos_r;
    used_nxt     = used_r;
    push_rem_nxt = push_rem_r;
    pop_rem_nxt  = pop_rem_r;
    plen_nxt     = plen_r;
    msgs_nxt     = msgs_r;
    pop_ptr_nxt  = pop_ptr_r;
    first_nxt    = first_r;
    hcnt_nxt     = hcnt_r;
    hdr_len_nxt  = hdr_len_r;
    wa_nxt       = wa_r;
    lo_nxt       = lo_r;
    ram_we       = 1'b0;
    ram_waddr    = wa_r;
    ram_wdata    = hdr_byte;
    ram_raddr    = pop_ptr_r;
    res_load     = 1'b0;
    res_status   = lpmr_pkg::STS_OK;
    res_byte     = '0;
    res_len      = '0;
    res_first    = 1'b0;
    res_last     = 1'b0;

    if (cfg_fire) begin
      // New ring size empties the ring.
      size_nxt     = cfg_size;
      wpos_nxt     = '0;
      cpos_nxt     = '0;
      rpos_nxt     = '0;
      used_nxt     = '0;
      push_rem_nxt = '0;
      pop_rem_nxt  = '0;
      plen_nxt     = '0;
      msgs_nxt     = '0;
      pop_ptr_nxt  = '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            case (in_mode)
              lpmr_pkg::MODE_HDR: begin
                res_load = 1'b1;
                if (push_rem_r != '0) begin
                  res_status = lpmr_pkg::STS_SEQ;
                end else if (too_long || !need_fits) begin
                  res_status = lpmr_pkg::STS_FULL;
                end else begin
                  // Reserve header plus payload, then write the header bytes.
                  wpos_nxt     = wpos_adv;
                  used_nxt     = used_r + PW'(need);
                  push_rem_nxt = in_msg_length;
                  hdr_len_nxt  = in_msg_length;
                  wa_nxt       = wpos_r;
                  hcnt_nxt     = '0;
                  state_nxt    = ST_HDR_WR;
                  if (in_msg_length == '0) begin
                    cpos_nxt = wpos_adv;
                    msgs_nxt = cnt_inc(msgs_r);
                  end
                end
              end
              lpmr_pkg::MODE_BYTE: begin
                res_load = 1'b1;
                if (push_rem_r == '0) begin
                  res_status = lpmr_pkg::STS_SEQ;
                end else begin
                  // Store the byte; commit on the last one.
                  ram_we       = 1'b1;
                  ram_waddr    = pl_addr;
                  ram_wdata    = in_data_byte;
                  push_rem_nxt = push_rem_r - LW'(1);
                  if (push_rem_r == LW'(1)) begin
                    cpos_nxt = wpos_r;
                    msgs_nxt = cnt_inc(msgs_r);
                  end
                end
              end
              lpmr_pkg::MODE_POP: begin
                if (pop_rem_r == '0) begin
                  if (rpos_r == cpos_r) begin
                    res_load   = 1'b1;
                    res_status = lpmr_pkg::STS_EMPTY;
                  end else begin
                    // Fetch the low header byte.
                    ram_raddr = rpos_r;
                    state_nxt = ST_HDR_LO;
                  end
                end else begin
                  ram_raddr = pop_ptr_r;
                  first_nxt = 1'b0;
                  state_nxt = ST_POP_OUT;
                end
              end
              default: begin
                res_load   = 1'b1;
                res_status = lpmr_pkg::STS_SEQ;
              end
            endcase
          end
        end
        ST_HDR_WR: begin
          // One header byte per cycle.
          ram_we    = 1'b1;
          ram_waddr = wa_r;
          ram_wdata = hdr_byte;
          wa_nxt    = inc_wrap(wa_r, size_r);
          hcnt_nxt  = hcnt_r + HCW'(1);
          if (hcnt_r == HCW'(HEADER_BYTES - 1)) begin
            state_nxt = ST_IDLE;
          end
        end
        ST_HDR_LO: begin
          // Hold the low byte, fetch the next one.
          lo_nxt    = ram_rdata;
          ram_raddr = inc_wrap(rpos_r, size_r);
          state_nxt = ST_HDR_LEN;
        end
        ST_HDR_LEN: begin
          plen_nxt  = hlen;
          first_nxt = 1'b1;
          if (hlen == '0) begin
            // Empty message: one beat, then release the header.
            res_load  = 1'b1;
            res_first = 1'b1;
            res_last  = 1'b1;
            rpos_nxt  = hdr_end;
            used_nxt  = sub_sat(used_r, CW'(HEADER_BYTES));
            msgs_nxt  = cnt_dec(msgs_r);
            state_nxt = ST_IDLE;
          end else begin
            pop_rem_nxt = hlen;
            ram_raddr   = hdr_end;
            pop_ptr_nxt = hdr_end;
            state_nxt   = ST_POP_OUT;
          end
        end
        ST_POP_OUT: begin
          // Hand out the byte; release the message after its last byte.
          res_load    = 1'b1;
          res_byte    = ram_rdata;
          res_len     = plen_r;
          res_first   = first_r;
          pop_ptr_nxt = inc_wrap(pop_ptr_r, size_r);
          pop_rem_nxt = pop_rem_r - LW'(1);
          state_nxt   = ST_IDLE;
          if (pop_rem_r == LW'(1)) begin
            res_last = 1'b1;
            rpos_nxt = inc_wrap(pop_ptr_r, size_r);
            used_nxt = sub_sat(used_r, CW'(plen_r) + CW'(HEADER_BYTES));
            msgs_nxt = cnt_dec(msgs_r);
          end
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      size_r      <= SW'(SIZE_RST);
      wpos_r      <= '0;
      cpos_r      <= '0;
      rpos_r      <= '0;
      used_r      <= '0;
      push_rem_r  <= '0;
      pop_rem_r   <= '0;
      plen_r      <= '0;
      msgs_r      <= '0;
      pop_ptr_r   <= '0;
      first_r     <= 1'b0;
      hcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      size_r     <= size_nxt;
      wpos_r     <= wpos_nxt;
      cpos_r     <= cpos_nxt;
      rpos_r     <= rpos_nxt;
      used_r     <= used_nxt;
      push_rem_r <= push_rem_nxt;
      pop_rem_r  <= pop_rem_nxt;
      plen_r     <= plen_nxt;
      msgs_r     <= msgs_nxt;
      pop_ptr_r  <= pop_ptr_nxt;
      first_r    <= first_nxt;
      hcnt_r     <= hcnt_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    hdr_len_r <= hdr_len_nxt;
    wa_r      <= wa_nxt;
    lo_r      <= lo_nxt;
    if (res_load) begin
      out_status_r        <= res_status;
      out_read_byte_r     <= res_byte;
      out_read_length_r   <= res_len;
      out_first_r         <= res_first;
      out_last_r          <= res_last;
      out_free_bytes_r    <= lpmr_pkg::FREE_W'(size_m1 - used_nxt);
      out_message_count_r <= msgs_nxt;
    end
  end

  lpmr_ram #(
    .WIDTH (BW),
    .DEPTH (RING_DEPTH)
  ) u_ring_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_read_byte     = out_read_byte_r;
  assign out_read_length   = out_read_length_r;
  assign out_first         = out_first_r;
  assign out_last          = out_last_r;
  assign out_free_bytes    = out_free_bytes_r;
  assign out_message_count = out_message_count_r;

endmodule

>>> verif/testbench.sv
// Self-checking testbench of the length-prefixed message ring with its own predictor.
`timescale 1ns / 100ps

module testbench;
  import lpmr_pkg::*;

  localparam int unsigned DEPTH          = RING_DEPTH_DEF;
  localparam int unsigned HDR_LEN        = HEADER_BYTES_DEF;
  localparam logic [MODE_W-1:0] MODE_BAD = 2'd3;
  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned LONG_HOLD      = 150;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    status_t             status;
    logic [BYTE_W-1:0]   read_byte;
    logic [LEN_W-1:0]    read_length;
    logic                first;
    logic                last;
    logic [FREE_W-1:0]   free_bytes;
    logic [COUNT_W-1:0]  message_count;
  } ring_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [MODE_W-1:0]   in_mode;
  logic [LEN_W-1:0]    in_msg_length;
  logic [BYTE_W-1:0]   in_data_byte;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] out_status;
  logic [BYTE_W-1:0]   out_read_byte;
  logic [LEN_W-1:0]    out_read_length;
  logic                out_first;
  logic                out_last;
  logic [FREE_W-1:0]   out_free_bytes;
  logic [COUNT_W-1:0]  out_message_count;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [SIZE_W-1:0]   cfg_data;

  ring_result_t expected_beats[$];
  int unsigned  fault_count = 0;
  int unsigned  items_sent = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  hold_req = 0;
  int unsigned  hold_ack = 0;
  bit           quiet = 1'b0;

  length_prefixed_message_ring uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_msg_length     (in_msg_length),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_read_byte     (out_read_byte),
    .out_read_length   (out_read_length),
    .out_first         (out_first),
    .out_last          (out_last),
    .out_free_bytes    (out_free_bytes),
    .out_message_count (out_message_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0] ring_mem [DEPTH];
  logic [SIZE_W-1:0] size_reg;
  int unsigned wr_ptr, commit_ptr, rd_ptr, held_bytes;
  int unsigned bytes_owed, pop_left, pop_len, waiting_msgs;

  // Clamp the size register to the usable range
  function automatic int unsigned ring_span();
    if (size_reg < MIN_SIZE) return MIN_SIZE;
    if (size_reg > DEPTH) return DEPTH;
    return size_reg;
  endfunction

  function automatic int unsigned ring_at(int unsigned pos, int unsigned offs);
    return (pos + offs) % ring_span();
  endfunction

  // One byte of slack is always kept
  function automatic int unsigned room_left();
    return (held_bytes >= ring_span() - 1) ? 0 : ring_span() - 1 - held_bytes;
  endfunction

  function automatic void empty_ring();
    wr_ptr       = 0;
    commit_ptr   = 0;
    rd_ptr       = 0;
    held_bytes   = 0;
    bytes_owed   = 0;
    pop_left     = 0;
    pop_len      = 0;
    waiting_msgs = 0;
  endfunction

  function automatic void reset_predictor();
    for (int i = 0; i < DEPTH; i++) ring_mem[i] = '0;
    size_reg = SIZE_W'(RESET_SIZE);
    empty_ring();
  endfunction

  // Make the open message visible to pops
  function automatic void close_message();
    commit_ptr = wr_ptr;
    if (waiting_msgs < COUNT_MAX) waiting_msgs++;
  endfunction

  // Work out the result beat of one accepted item and advance the ring
  function automatic ring_result_t predict_ring_step(logic [MODE_W-1:0] mode,
                                                     logic [LEN_W-1:0] len,
                                                     logic [BYTE_W-1:0] data);
    ring_result_t r;
    int unsigned  need, back, offs, whole;
    logic [63:0]  hdr;
    r        = '0;
    r.status = STS_OK;
    case (mode)
      MODE_HDR: begin
        need = len + HDR_LEN;
        if (bytes_owed != 0) begin
          r.status = STS_SEQ;
        end else if ((HDR_LEN < 2 && len > NARROW_MAX) || need > room_left()) begin
          r.status = STS_FULL;
        end else begin
          for (int i = 0; i < HDR_LEN; i++)
            ring_mem[ring_at(wr_ptr, i)] = BYTE_W'(64'(len) >> (8 * i));
          wr_ptr      = ring_at(wr_ptr, need);
          held_bytes += need;
          bytes_owed  = len;
          if (len == 0) close_message();
        end
      end
      MODE_BYTE: begin
        if (bytes_owed == 0) begin
          r.status = STS_SEQ;
        end else begin
          back = bytes_owed % ring_span();
          ring_mem[ring_at(wr_ptr, ring_span() - back)] = data;
          bytes_owed--;
          if (bytes_owed == 0) close_message();
        end
      end
      MODE_POP: begin
        if (pop_left == 0 && rd_ptr == commit_ptr) begin
          r.status = STS_EMPTY;
        end else begin
          // Fetch the length header when a new message starts
          if (pop_left == 0) begin
            hdr = '0;
            for (int i = 0; i < HDR_LEN; i++)
              hdr |= 64'(ring_mem[ring_at(rd_ptr, i)]) << (8 * i);
            pop_len  = hdr[LEN_W-1:0];
            pop_left = pop_len;
            r.first  = 1'b1;
          end
          whole         = pop_len + HDR_LEN;
          r.read_length = LEN_W'(pop_len);
          if (pop_left != 0) begin
            offs        = HDR_LEN + (pop_len - pop_left);
            r.read_byte = ring_mem[ring_at(rd_ptr, offs)];
            pop_left--;
          end
          // Release the whole message after its last byte
          if (pop_left == 0) begin
            r.last     = 1'b1;
            rd_ptr     = ring_at(rd_ptr, whole);
            held_bytes = (held_bytes >= whole) ? held_bytes - whole : 0;
            if (waiting_msgs > 0) waiting_msgs--;
          end
        end
      end
      default: r.status = STS_SEQ;
    endcase
    r.free_bytes    = FREE_W'(room_left());
    r.message_count = COUNT_W'(waiting_msgs);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
    fault_count++;
  endtask

  task automatic check_result();
    ring_result_t want;
    if (expected_beats.size() == 0) begin
      $display("%0t: result beat with nothing expected: expected none, actual status %0d",
               $time, out_status);
      fault_count++;
      return;
    end
    want = expected_beats.pop_front();
    if (out_status !== want.status) flag_mismatch("status", want.status, out_status);
    if (out_read_byte !== want.read_byte)
      flag_mismatch("read_byte", want.read_byte, out_read_byte);
    if (out_read_length !== want.read_length)
      flag_mismatch("read_length", want.read_length, out_read_length);
    if (out_first !== want.first) flag_mismatch("first", want.first, out_first);
    if (out_last !== want.last) flag_mismatch("last", want.last, out_last);
    if (out_free_bytes !== want.free_bytes)
      flag_mismatch("free_bytes", want.free_bytes, out_free_bytes);
    if (out_message_count !== want.message_count)
      flag_mismatch("message_count", want.message_count, out_message_count);
  endtask

  // Check results, track register writes and predict each accepted beat
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_result();
      if (cfg_valid && cfg_ready) begin
        size_reg = cfg_data;
        empty_ring();
      end
      if (in_valid && !in_stall)
        expected_beats.push_back(predict_ring_step(in_mode, in_msg_length, in_data_byte));
    end
  end

  // Stall the result channel: random bursts, or one long hold when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_ack) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_ack = hold_req;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Count cycles with no beat on any channel
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Offer one beat, with an optional gap first, and hold it until accepted
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [LEN_W-1:0] len,
                           input logic [BYTE_W-1:0] data);
    int unsigned gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_msg_length <= len;
    in_data_byte  <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic push_header(input logic [LEN_W-1:0] len);
    send_item(MODE_HDR, len, BYTE_W'($urandom));
  endtask

  task automatic push_byte(input logic [BYTE_W-1:0] data);
    send_item(MODE_BYTE, LEN_W'($urandom), data);
  endtask

  task automatic pop_byte();
    send_item(MODE_POP, LEN_W'($urandom), BYTE_W'($urandom));
  endtask

  // Drop valid and wait until every expected beat has come back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_ring_size(input logic [SIZE_W-1:0] size);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= size;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed messages with interleaved pops, plus noise and broken messages
  task automatic random_traffic(input int unsigned count);
    int unsigned stop_at, len, pick;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_item(MODE_W'($urandom_range(0, 3)), LEN_W'($urandom), BYTE_W'($urandom));
      end else if (pick <= 3) begin
        repeat ($urandom_range(1, 8)) pop_byte();
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 12);
        push_header(LEN_W'(len));
        for (int k = 0; k < len; k++) begin
          // abandon the message part way now and then
          if ($urandom_range(0, 39) == 0) break;
          if ($urandom_range(0, 1) == 0) pop_byte();
          push_byte(BYTE_W'($urandom));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Status codes, zero-length message and sequence errors at the reset size
  task automatic test_status_codes();
    pop_byte();
    push_byte(8'hFF);
    send_item(MODE_BAD, '1, '1);
    push_header('1);
    push_header('0);
    pop_byte();
    push_header(LEN_W'(3));
    push_header(LEN_W'(5));
    pop_byte();
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h5A);
    push_byte(8'hA5);
    repeat (4) pop_byte();
  endtask

  // Sizes below the minimum and above the depth, and exact fits
  task automatic test_size_limits();
    write_ring_size('0);
    push_header(LEN_W'(MIN_SIZE - 1 - HDR_LEN));
    for (int k = 0; k < MIN_SIZE - 1 - HDR_LEN; k++) push_byte(BYTE_W'(1 << k));
    push_header('0);
    pop_byte();
    pop_byte();
    write_ring_size(SIZE_W'(MIN_SIZE - 1));
    push_header(LEN_W'(MIN_SIZE - HDR_LEN));
    write_ring_size('1);
    push_header(LEN_W'(DEPTH - 1 - HDR_LEN));
    push_header('0);
    write_ring_size(SIZE_W'(DEPTH + 1));
    push_header(LEN_W'(DEPTH - HDR_LEN));
  endtask

  // Fill the ring with empty messages up to the highest count
  task automatic test_message_count_ceiling();
    write_ring_size(SIZE_W'(RESET_SIZE));
    repeat (COUNT_MAX) push_header('0);
    push_header('0);
    repeat (12) pop_byte();
  endtask

  // One message of the greatest length that fits
  task automatic test_longest_message();
    write_ring_size(SIZE_W'(RESET_SIZE));
    push_header(LEN_W'(DEPTH - 1 - HDR_LEN));
    repeat (DEPTH - 1 - HDR_LEN) push_byte(BYTE_W'($urandom));
    push_header('0);
    repeat (DEPTH - HDR_LEN) pop_byte();
  endtask

  // Hold the result channel off for a long stretch while beats keep being offered
  task automatic test_backpressure();
    write_ring_size(SIZE_W'(64));
    hold_req++;
    push_header(LEN_W'(20));
    repeat (20) push_byte(BYTE_W'($urandom));
    repeat (22) pop_byte();
  endtask

  task automatic test_random_ring(input logic [SIZE_W-1:0] size, input int unsigned count);
    write_ring_size(size);
    random_traffic(count);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_mode       = MODE_HDR;
    in_msg_length = '0;
    in_data_byte  = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    reset_predictor();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_status_codes();
    test_size_limits();
    test_message_count_ceiling();
    test_longest_message();
    test_backpressure();
    test_random_ring(SIZE_W'(MIN_SIZE), 200);
    test_random_ring(SIZE_W'($urandom_range(MIN_SIZE + 1, 300)), 200);
    test_random_ring(SIZE_W'($urandom), 200);
    // last stretch runs without idling on either side
    quiet = 1'b1;
    test_random_ring(SIZE_W'(RESET_SIZE), 200);
    settle();

    if (expected_beats.size() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time, expected_beats.size());
      fault_count++;
    end
    if (fault_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
